/* hdl/ivs_pkg.sv */
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared types and constants of the intervalometer sequencer: field widths,
// status codes, configuration register indexes, shutter edge codes and reset values.
// ----------------------------------------------------------------------------
package ivs_pkg;

  // field widths
  localparam int FRAMES_W  = 14;
  localparam int TICKCFG_W = 12;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = 28;
  localparam int REMAIN_W  = 32;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = FRAMES_W;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE     = 2'd0,
    ST_WAITING  = 2'd1,
    ST_EXPOSING = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT    = 2'd0,
    CFG_INITIAL_DELAY  = 2'd1,
    CFG_EXPOSURE_TICKS = 2'd2,
    CFG_GAP_TICKS      = 2'd3
  } cfg_idx_t;

  // shutter edge codes
  localparam logic EDGE_OPEN  = 1'b0;
  localparam logic EDGE_CLOSE = 1'b1;

  // elapsed counter values: restart value and saturation limit
  localparam logic [ELAPSED_W-1:0] ELAPSED_RESET = {ELAPSED_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {1'b0, {(ELAPSED_W-1){1'b1}}};

  // register reset values
  localparam logic [TICKCFG_W-1:0] EXPOSURE_RESET = TICKCFG_W'(1);

endpackage

/* hdl/ivs_if.sv */
// ----------------------------------------------------------------------------
// ivs_if
// Valid/ready channels of the intervalometer sequencer: tick input channel
// and result channel.
// ----------------------------------------------------------------------------

// tick / restart words
interface ivs_in_if import ivs_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// result words
interface ivs_out_if import ivs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic                       shutter_edge;
  logic signed [TOTAL_W-1:0]  total_ticks;
  logic signed [REMAIN_W-1:0] remaining_ticks;

  modport source (output valid, output status, output shutter_edge,
                  output total_ticks, output remaining_ticks, input ready);
  modport sink   (input valid, input status, input shutter_edge,
                  input total_ticks, input remaining_ticks, output ready);
endinterface

/* hdl/intervalometer_sequencer_top.sv */
// ----------------------------------------------------------------------------
// intervalometer_sequencer_top
// Time-lapse shutter sequencer: each tick word advances a saturating elapsed
// counter and yields status, shutter edge, planned total and remaining time.
// Pipeline: an accepted word enters the input register, and its results are
//   registered into the result register when the result slot frees.
// Throughput: one word per cycle unless the result channel stalls; the compute
//   logic has two 14x13 multiplies, compares and a saturating 34-bit subtract.
// Reset (synchronous, rst_n low): registers to their reset values, elapsed to
//   all ones, frame count done to zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
module intervalometer_sequencer_top import ivs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ivs_in_if.sink                in_chan,
  ivs_out_if.source             out_chan
);

  // configuration registers
  logic [FRAMES_W-1:0]  frame_count_r;
  logic [TICKCFG_W-1:0] initial_delay_r;
  logic [TICKCFG_W-1:0] exposure_ticks_r;
  logic [TICKCFG_W-1:0] gap_ticks_r;

  // sequencer state
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [FRAMES_W-1:0]  frames_done_r, frames_done_nxt;

  // input register
  logic s1_valid_r;
  logic s1_restart_r;
  logic s1_go;

  // result register
  logic                       out_valid_r;
  status_t                    status_r, status_nxt;
  logic                       edge_r, edge_nxt;
  logic signed [TOTAL_W-1:0]  total_r;
  logic signed [REMAIN_W-1:0] remain_r, remain_nxt;

  // compute-cycle terms
  logic [TICKCFG_W:0]        period;
  logic [26:0]               start_tick;
  logic [26:0]               plan_prod;
  logic signed [29:0]        total_full;
  logic signed [33:0]        cur_tick;
  logic signed [33:0]        open_at;
  logic signed [33:0]        close_at;
  logic signed [33:0]        remain_full;
  logic                      in_delay;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r    <= '0;
      initial_delay_r  <= '0;
      exposure_ticks_r <= EXPOSURE_RESET;
      gap_ticks_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_COUNT:    frame_count_r    <= cfg_wdata[FRAMES_W-1:0];
        CFG_INITIAL_DELAY:  initial_delay_r  <= cfg_wdata[TICKCFG_W-1:0];
        CFG_EXPOSURE_TICKS: exposure_ticks_r <= cfg_wdata[TICKCFG_W-1:0];
        CFG_GAP_TICKS:      gap_ticks_r      <= cfg_wdata[TICKCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on whenever the result slot frees
  assign s1_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_restart_r <= in_chan.restart;
    end
  end

  // plan arithmetic
  assign period     = {1'b0, exposure_ticks_r} + {1'b0, gap_ticks_r};
  assign start_tick = 27'(frames_done_r) * 27'(period);
  assign plan_prod  = 27'(frame_count_r) * 27'(period);
  assign total_full = $signed({3'b0, plan_prod}) - $signed({18'b0, gap_ticks_r})
                    + $signed({18'b0, initial_delay_r});

  // elapsed counter, saturating at the signed maximum
  always_comb begin
    if (s1_restart_r) begin
      elapsed_nxt = ELAPSED_RESET;
    end else if (elapsed_r != ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + ELAPSED_W'(1);
    end else begin
      elapsed_nxt = elapsed_r;
    end
  end

  // time since the initial delay against this frame's open and close points
  assign cur_tick = $signed({{2{elapsed_nxt[ELAPSED_W-1]}}, elapsed_nxt})
                  - $signed({22'b0, initial_delay_r});
  assign open_at  = $signed({7'b0, start_tick});
  assign close_at = open_at + $signed({22'b0, exposure_ticks_r});
  assign in_delay = (initial_delay_r != '0) &&
                    ($signed(elapsed_nxt) < $signed({20'b0, initial_delay_r}));

  // status and frame advance
  always_comb begin
    status_nxt      = ST_NONE;
    edge_nxt        = EDGE_OPEN;
    frames_done_nxt = frames_done_r;
    if (s1_restart_r) begin
      frames_done_nxt = '0;
    end else if (frames_done_r >= frame_count_r) begin
      status_nxt = ST_FINISHED;
    end else if (in_delay) begin
      status_nxt = ST_WAITING;
    end else if (cur_tick == open_at) begin
      status_nxt = ST_EXPOSING;
    end else if (cur_tick == close_at) begin
      status_nxt      = ST_EXPOSING;
      edge_nxt        = EDGE_CLOSE;
      frames_done_nxt = frames_done_r + FRAMES_W'(1);
    end else if (cur_tick <= open_at) begin
      status_nxt = ST_WAITING;
    end
  end

  // remaining time, saturated to 32 bits
  assign remain_full = $signed({{4{total_full[29]}}, total_full})
                     - $signed({{2{elapsed_nxt[ELAPSED_W-1]}}, elapsed_nxt});
  always_comb begin
    if (remain_full[33:31] == 3'b000 || remain_full[33:31] == 3'b111) begin
      remain_nxt = remain_full[REMAIN_W-1:0];
    end else if (remain_full[33]) begin
      remain_nxt = {1'b1, {(REMAIN_W-1){1'b0}}};
    end else begin
      remain_nxt = {1'b0, {(REMAIN_W-1){1'b1}}};
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r     <= ELAPSED_RESET;
      frames_done_r <= '0;
    end else if (s1_go) begin
      elapsed_r     <= elapsed_nxt;
      frames_done_r <= frames_done_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      status_r <= status_nxt;
      edge_r   <= edge_nxt;
      total_r  <= total_full[TOTAL_W-1:0];
      remain_r <= remain_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = status_r;
  assign out_chan.shutter_edge    = edge_r;
  assign out_chan.total_ticks     = total_r;
  assign out_chan.remaining_ticks = remain_r;

  // a close edge counts exactly one frame
  a_close_counts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_restart_r && status_nxt == ST_EXPOSING && edge_nxt == EDGE_CLOSE
    |=> frames_done_r == $past(frames_done_r) + FRAMES_W'(1))
    else $error("close edge did not advance frame count");

  // a restart word clears the counters and reports none
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_restart_r
    |=> elapsed_r == ELAPSED_RESET && frames_done_r == '0 && status_r == ST_NONE)
    else $error("restart did not reinitialize counters");

  // close edge only comes with exposing status
  a_edge_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && edge_r == EDGE_CLOSE |-> status_r == ST_EXPOSING)
    else $error("close edge outside exposing status");

  // input backpressure only when both stages hold a word
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule
